@@ rtl/wnm_pkg.sv @@
`default_nettype none

package wnm_pkg;

	localparam int PatternMax = 64;
	localparam int IdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1;
	localparam int LenW = $clog2(PatternMax + 1);

	localparam logic [7:0] StarChar = 8'h2A;
	localparam logic [7:0] AnyChar  = 8'h3F;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_NAME   = 2'd2,
		MODE_END    = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic matched;
		logic pattern_truncated;
	} result_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic            clear;
		logic            write;
		logic            step;
		logic            at_start;
		logic [7:0]      chr;
		logic [LenW-1:0] len;
	} cell_ctrl_t;

	typedef struct packed {
		logic star;
		logic hit;
		logic seed;
		logic prev;
		logic lead;
	} cell_out_t;

	function automatic logic [7:0] ascii_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/wnm_cell.sv @@
`default_nettype none

module wnm_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire wnm_pkg::cell_ctrl_t        ctrl,
	input  wire logic [wnm_pkg::IdxW-1:0]   idx,
	input  wire logic                       diag_in,
	input  wire logic                       lead_in,
	input  wire logic                       fill_in,
	output wnm_pkg::cell_out_t              cell_out
);
	import wnm_pkg::*;

	logic [7:0] chr_q;
	logic       lead_q;
	logic       match_q;
	logic       valid;
	logic       is_star;
	logic       prev;
	logic       wr_here;

	assign valid   = ctrl.len > LenW'(idx);
	assign is_star = chr_q == StarChar;
	// before the first name character the row starts from the leading-star run
	assign prev    = valid & (ctrl.at_start ? lead_q : match_q);
	assign wr_here = ctrl.write & (ctrl.len == LenW'(idx));

	always_comb begin
		cell_out.star = valid & is_star;
		cell_out.hit  = valid & ~is_star & (chr_q == AnyChar || chr_q == ctrl.chr) & diag_in;
		cell_out.seed = valid & is_star & prev;
		cell_out.prev = prev;
		cell_out.lead = lead_q;
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			chr_q  <= ctrl.chr;
			lead_q <= (ctrl.chr == StarChar) & lead_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.clear) begin
			match_q <= 1'b0;
		end else if (ctrl.step) begin
			match_q <= cell_out.hit | fill_in;
		end
	end

endmodule

`default_nettype wire

@@ rtl/wildcard_name_matcher.sv @@
`default_nettype none

// Glob matcher for names: one input transfer per clock in every mode while
// item_stall is low. Each pattern position is a cell holding its lower-cased
// character and its match bit; a name character updates all cells in the same
// cycle, with runs of '*' closed by one carry-propagate add across the row. The
// result of an end-of-name item is registered into the output register when that
// register is free or being read; a second result register absorbs one more result
// while the output is stalled, and item_stall rises only when both are full. Pattern
// characters past 64 are dropped and flagged until the next clear.
module wildcard_name_matcher (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_stall,
	input  wire wnm_pkg::item_t item,
	output logic          result_valid,
	input  wire logic     result_stall,
	output wnm_pkg::result_t result
);
	import wnm_pkg::*;

	logic            accept;
	logic            is_clear;
	logic            is_append;
	logic            is_name;
	logic            is_end;
	logic [LenW-1:0] len_q;
	logic [LenW-1:0] len_m1;
	logic            ovf_q;
	logic            at_start_q;
	cell_ctrl_t      ctrl;
	cell_out_t       cell_outs [PatternMax];
	logic [PatternMax-1:0] star_vec;
	logic [PatternMax-1:0] hit_vec;
	logic [PatternMax-1:0] seed_vec;
	logic [PatternMax-1:0] prev_vec;
	logic [PatternMax-1:0] lead_vec;
	logic [PatternMax-1:0] seeds;
	logic [PatternMax-1:0] sum;
	logic [PatternMax-1:0] fill;
	logic            hit;
	result_t         new_res;
	logic            res_take;
	logic            out_v_q;
	logic            skid_v_q;
	result_t         out_q;
	result_t         skid_q;

	assign accept    = item_valid & ~item_stall;
	assign is_clear  = item.mode == MODE_CLEAR;
	assign is_append = item.mode == MODE_APPEND;
	assign is_name   = item.mode == MODE_NAME;
	assign is_end    = item.mode == MODE_END;

	always_comb begin
		ctrl.clear    = accept & ~is_name;
		ctrl.write    = accept & is_append;
		ctrl.step     = accept & is_name;
		ctrl.at_start = at_start_q;
		ctrl.chr      = ascii_lower(item.char_code);
		ctrl.len      = len_q;
	end

	for (genvar j = 0; j < PatternMax; j++) begin : g_cell
		if (j == 0) begin : g_first
			wnm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.idx      (IdxW'(j)),
				.diag_in  (at_start_q),
				.lead_in  (1'b1),
				.fill_in  (fill[j]),
				.cell_out (cell_outs[j])
			);
		end else begin : g_rest
			wnm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.idx      (IdxW'(j)),
				.diag_in  (prev_vec[j-1]),
				.lead_in  (lead_vec[j-1]),
				.fill_in  (fill[j]),
				.cell_out (cell_outs[j])
			);
		end
	end

	always_comb begin
		for (int k = 0; k < PatternMax; k++) begin
			star_vec[k] = cell_outs[k].star;
			hit_vec[k]  = cell_outs[k].hit;
			seed_vec[k] = cell_outs[k].seed;
			prev_vec[k] = cell_outs[k].prev;
			lead_vec[k] = cell_outs[k].lead;
		end
	end

	// A '*' run fills upward from its lowest seed: in star_vec + seeds the carry
	// runs from that seed to the top of the run, so seeds plus carry-ins mark it.
	assign seeds = seed_vec | ((hit_vec << 1) & star_vec);
	assign sum   = star_vec + seeds;
	assign fill  = star_vec & (seeds | (sum ^ star_vec ^ seeds));

	assign len_m1 = len_q - LenW'(1);
	assign hit    = (len_q == '0) ? at_start_q : prev_vec[len_m1[IdxW-1:0]];

	always_comb begin
		new_res.matched           = hit;
		new_res.pattern_truncated = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			ovf_q      <= 1'b0;
			at_start_q <= 1'b1;
		end else if (accept) begin
			at_start_q <= ~is_name;
			if (is_clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (is_append) begin
				if (len_q < LenW'(PatternMax)) begin
					len_q <= len_q + LenW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign res_take     = out_v_q & ~result_stall;
	assign result_valid = out_v_q;
	assign result       = out_q;
	assign item_stall   = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res_take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || res_take) begin
			out_v_q <= accept & is_end;
		end else if (accept && is_end) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (res_take) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || res_take) begin
			if (accept && is_end) begin
				out_q <= new_res;
			end
		end else if (accept && is_end) begin
			skid_q <= new_res;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with empty output register");

	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LenW'(PatternMax))
		else $error("pattern length beyond capacity");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LenW'(PatternMax))
		else $error("truncation flag set with room left");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_clear |=> len_q == '0 && !ovf_q && at_start_q)
		else $error("clear did not empty the pattern");

endmodule

`default_nettype wire
